// ===== rtl/core/sqtf_pkg.sv =====
// Shared types, constants and codes of the scissored quad fill core.
`timescale 1ns / 1ps
`default_nettype none

package sqtf_pkg;

  // Largest buffer dimension in pixels; the buffer size is clipped to it.
  localparam int MAX_DIM    = 4096;

  // Fixed field widths.
  localparam int EDGE_W     = 14;
  localparam int CFG_DIM_W  = 13;
  localparam int ADDR_W     = 32;
  localparam int STRIDE_W   = 21;
  localparam int COLOR_W    = 32;
  localparam int MASK_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Bytes in one quad write and the matching address shift.
  localparam int QUAD_BYTES = 16;
  localparam int QUAD_SHIFT = $clog2(QUAD_BYTES);

  // Widths that follow from the largest dimension.
  localparam int CLIP_W = $clog2(MAX_DIM + 1);
  localparam int QW     = CLIP_W - 1;
  localparam int CMP_W  = (EDGE_W > CLIP_W + 1) ? EDGE_W : CLIP_W + 1;
  localparam int LIM_W  = (CFG_DIM_W > CLIP_W) ? CFG_DIM_W : CLIP_W;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_WIDTH    = 2'd0,
    REG_BUFFER_HEIGHT   = 2'd1,
    REG_BASE_ADDRESS    = 2'd2,
    REG_ROW_PAIR_STRIDE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] buffer_width;
    logic [CFG_DIM_W-1:0] buffer_height;
    logic [ADDR_W-1:0]    base_address;
    logic [STRIDE_W-1:0]  row_pair_stride;
  } cfg_t;

  typedef struct packed {
    logic              busy;
    logic [CLIP_W-1:0] clip_top;
    logic [CLIP_W-1:0] clip_left;
    logic [CLIP_W-1:0] clip_bottom;
    logic [CLIP_W-1:0] clip_right;
    logic [QW-1:0]     cur_quad_row;
    logic [QW-1:0]     cur_quad_col;
    logic [ADDR_W-1:0] row_start_address;
    logic [COLOR_W-1:0] held_plane_color;
  } fill_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  quad_address;
    logic [MASK_W-1:0]  pixel_mask;
    logic [COLOR_W-1:0] plane_color;
    logic               last_write;
  } quad_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/sqtf_cmd_if.sv =====
// Command channel: start and step transactions into the fill core.
`timescale 1ns / 1ps
`default_nettype none

interface sqtf_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic                                 scissor_enable;
  logic signed [sqtf_pkg::EDGE_W-1:0]   scissor_top;
  logic signed [sqtf_pkg::EDGE_W-1:0]   scissor_left;
  logic signed [sqtf_pkg::EDGE_W-1:0]   scissor_bottom;
  logic signed [sqtf_pkg::EDGE_W-1:0]   scissor_right;
  logic [sqtf_pkg::COLOR_W-1:0]         fill_color;

  modport source (
    output valid, op, scissor_enable, scissor_top, scissor_left,
           scissor_bottom, scissor_right, fill_color,
    input  ready
  );
  modport sink (
    input  valid, op, scissor_enable, scissor_top, scissor_left,
           scissor_bottom, scissor_right, fill_color,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/sqtf_quad_if.sv =====
// Quad write channel: one 16-byte quad write per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface sqtf_quad_if;
  logic                          valid;
  logic                          ready;
  logic [sqtf_pkg::ADDR_W-1:0]   quad_address;
  logic [sqtf_pkg::MASK_W-1:0]   pixel_mask;
  logic [sqtf_pkg::COLOR_W-1:0]  plane_color;
  logic                          last_write;

  modport source (
    output valid, quad_address, pixel_mask, plane_color, last_write,
    input  ready
  );
  modport sink (
    input  valid, quad_address, pixel_mask, plane_color, last_write,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/sqtf_start_unit.sv =====
// Start decode: clip the rectangle, reorder the color, find the first row address.
`timescale 1ns / 1ps
`default_nettype none

module sqtf_start_unit (
  input  sqtf_pkg::cfg_t                      cfg,
  input  logic                                scissor_enable,
  input  logic signed [sqtf_pkg::EDGE_W-1:0]  scissor_top,
  input  logic signed [sqtf_pkg::EDGE_W-1:0]  scissor_left,
  input  logic signed [sqtf_pkg::EDGE_W-1:0]  scissor_bottom,
  input  logic signed [sqtf_pkg::EDGE_W-1:0]  scissor_right,
  input  logic [sqtf_pkg::COLOR_W-1:0]        fill_color,
  output sqtf_pkg::fill_state_t               st_next
);

  localparam int PROD_W = sqtf_pkg::QW + sqtf_pkg::STRIDE_W;

  function automatic logic [sqtf_pkg::CLIP_W-1:0] dim_limit(
    input logic [sqtf_pkg::CFG_DIM_W-1:0] d
  );
    logic [sqtf_pkg::LIM_W-1:0] dx;
    dx = sqtf_pkg::LIM_W'(d);
    if (dx > sqtf_pkg::LIM_W'(sqtf_pkg::MAX_DIM)) begin
      return sqtf_pkg::CLIP_W'(sqtf_pkg::MAX_DIM);
    end
    return sqtf_pkg::CLIP_W'(dx);
  endfunction

  function automatic logic [sqtf_pkg::CLIP_W-1:0] clamp_edge(
    input logic signed [sqtf_pkg::EDGE_W-1:0] v,
    input logic [sqtf_pkg::CLIP_W-1:0]        limit
  );
    logic signed [sqtf_pkg::CMP_W-1:0] vx;
    logic signed [sqtf_pkg::CMP_W-1:0] lx;
    vx = sqtf_pkg::CMP_W'(v);
    lx = $signed(sqtf_pkg::CMP_W'(limit));
    if (vx < 0) begin
      return '0;
    end
    if (vx > lx) begin
      return limit;
    end
    return vx[sqtf_pkg::CLIP_W-1:0];
  endfunction

  logic [sqtf_pkg::CLIP_W-1:0] w;
  logic [sqtf_pkg::CLIP_W-1:0] h;
  logic [sqtf_pkg::CLIP_W-1:0] top;
  logic [sqtf_pkg::CLIP_W-1:0] left;
  logic [sqtf_pkg::CLIP_W-1:0] bottom;
  logic [sqtf_pkg::CLIP_W-1:0] right;
  logic [sqtf_pkg::QW-1:0]     first_row;
  logic [PROD_W-1:0]           row_offset;

  always_comb begin
    w = dim_limit(cfg.buffer_width);
    h = dim_limit(cfg.buffer_height);
    if (scissor_enable) begin
      top    = clamp_edge(scissor_top, h);
      left   = clamp_edge(scissor_left, w);
      bottom = clamp_edge(scissor_bottom, h);
      right  = clamp_edge(scissor_right, w);
    end else begin
      top    = '0;
      left   = '0;
      bottom = h;
      right  = w;
    end
    first_row  = top[sqtf_pkg::CLIP_W-1:1];
    row_offset = PROD_W'(first_row) * PROD_W'(cfg.row_pair_stride);

    st_next.busy              = (top < bottom) && (left < right);
    st_next.clip_top          = top;
    st_next.clip_left         = left;
    st_next.clip_bottom       = bottom;
    st_next.clip_right        = right;
    st_next.cur_quad_row      = first_row;
    st_next.cur_quad_col      = left[sqtf_pkg::CLIP_W-1:1];
    st_next.row_start_address = cfg.base_address + sqtf_pkg::ADDR_W'(row_offset);
    st_next.held_plane_color  = {fill_color[31:24], fill_color[15:8],
                                 fill_color[23:16], fill_color[7:0]};
  end

endmodule

`default_nettype wire

// ===== rtl/core/sqtf_quad_step.sv =====
// Quad step: mask and address of the current quad, then advance the walk.
`timescale 1ns / 1ps
`default_nettype none

module sqtf_quad_step (
  input  sqtf_pkg::fill_state_t                st,
  input  logic [sqtf_pkg::STRIDE_W-1:0]        row_pair_stride,
  output sqtf_pkg::fill_state_t                st_next,
  output sqtf_pkg::quad_res_t                  res
);

  logic [sqtf_pkg::CLIP_W-1:0] right_m1;
  logic [sqtf_pkg::CLIP_W-1:0] bottom_m1;
  logic [sqtf_pkg::QW-1:0]     last_col;
  logic [sqtf_pkg::QW-1:0]     last_row;
  logic [sqtf_pkg::CLIP_W-1:0] x;
  logic [sqtf_pkg::CLIP_W-1:0] y;
  logic [sqtf_pkg::MASK_W-1:0] mask;

  always_comb begin
    mask = '0;
    for (int s = 0; s < sqtf_pkg::MASK_W; s++) begin
      x = {st.cur_quad_col, s[0]};
      y = {st.cur_quad_row, s[1]};
      mask[s] = (x >= st.clip_left) && (x < st.clip_right) &&
                (y >= st.clip_top) && (y < st.clip_bottom);
    end
  end

  always_comb begin
    right_m1  = st.clip_right - sqtf_pkg::CLIP_W'(1);
    bottom_m1 = st.clip_bottom - sqtf_pkg::CLIP_W'(1);
    last_col  = right_m1[sqtf_pkg::CLIP_W-1:1];
    last_row  = bottom_m1[sqtf_pkg::CLIP_W-1:1];

    res.quad_address = st.row_start_address +
                       sqtf_pkg::ADDR_W'({st.cur_quad_col, sqtf_pkg::QUAD_SHIFT'(0)});
    res.pixel_mask   = mask;
    res.plane_color  = st.held_plane_color;
    res.last_write   = 1'b0;

    st_next = st;
    if (st.cur_quad_col < last_col) begin
      st_next.cur_quad_col = st.cur_quad_col + sqtf_pkg::QW'(1);
    end else if (st.cur_quad_row < last_row) begin
      // wrap to the first column pair of the next row pair
      st_next.cur_quad_row      = st.cur_quad_row + sqtf_pkg::QW'(1);
      st_next.cur_quad_col      = st.clip_left[sqtf_pkg::CLIP_W-1:1];
      st_next.row_start_address = st.row_start_address +
                                  sqtf_pkg::ADDR_W'(row_pair_stride);
    end else begin
      st_next.busy   = 1'b0;
      res.last_write = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scissored_quad_tiled_fill_core.sv =====
// Top level of the scissored quad-tiled color fill core.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Role    Transaction
// -------  ------  ---------------------------------------------------------
// cmd      sink    start (clip rectangle, color) or step (issue one quad write)
// quad     source  one 16-byte quad write: address, pixel mask, color, last
// cfg      write   register write: buffer size, base address, row pair stride
//
// Each command is captured in the input register, then decoded and retired
// from it; without output stalls, one command and one quad write a cycle.
// The quad output register parts the two sides: a new command is taken while
// a finished write waits, as long as that command needs no output slot.
// Starts and idle steps retire even while the output register is full.
// rst (synchronous) clears the pipeline valids and the busy flag and loads
// the register reset values; no clearing pass is needed.

module scissored_quad_tiled_fill_core (
  input  logic                                clk,
  input  logic                                rst,
  sqtf_cmd_if.sink                            cmd,
  sqtf_quad_if.source                         quad,
  input  logic                                cfg_we,
  input  logic [sqtf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sqtf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration registers
  sqtf_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_width    <= sqtf_pkg::CFG_DIM_W'(640);
      cfg.buffer_height   <= sqtf_pkg::CFG_DIM_W'(480);
      cfg.base_address    <= '0;
      cfg.row_pair_stride <= sqtf_pkg::STRIDE_W'(5120);
    end else if (cfg_we) begin
      unique case (sqtf_pkg::reg_idx_t'(cfg_index))
        sqtf_pkg::REG_BUFFER_WIDTH:
          cfg.buffer_width <= cfg_data[sqtf_pkg::CFG_DIM_W-1:0];
        sqtf_pkg::REG_BUFFER_HEIGHT:
          cfg.buffer_height <= cfg_data[sqtf_pkg::CFG_DIM_W-1:0];
        sqtf_pkg::REG_BASE_ADDRESS:
          cfg.base_address <= cfg_data[sqtf_pkg::ADDR_W-1:0];
        sqtf_pkg::REG_ROW_PAIR_STRIDE:
          cfg.row_pair_stride <= cfg_data[sqtf_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                                cmd_valid_r;
  logic                                op_r;
  logic                                scissor_enable_r;
  logic signed [sqtf_pkg::EDGE_W-1:0]  scissor_top_r;
  logic signed [sqtf_pkg::EDGE_W-1:0]  scissor_left_r;
  logic signed [sqtf_pkg::EDGE_W-1:0]  scissor_bottom_r;
  logic signed [sqtf_pkg::EDGE_W-1:0]  scissor_right_r;
  logic [sqtf_pkg::COLOR_W-1:0]        fill_color_r;

  // walk state and output register
  sqtf_pkg::fill_state_t st;
  sqtf_pkg::fill_state_t st_next;
  sqtf_pkg::fill_state_t start_next;
  sqtf_pkg::fill_state_t step_next;
  sqtf_pkg::quad_res_t   step_res;
  sqtf_pkg::quad_res_t   quad_r;
  logic                  quad_valid_r;

  logic step_item;
  logic has_res;
  logic out_free;
  logic proc_fire;
  logic cmd_fire;

  assign step_item = (op_r == sqtf_pkg::OP_STEP);
  assign has_res   = step_item && st.busy;
  assign out_free  = !quad_valid_r || quad.ready;
  // retire the held command unless it needs the output slot and that is taken
  assign proc_fire = cmd_valid_r && (!has_res || out_free);
  assign cmd.ready = !cmd_valid_r || proc_fire;
  assign cmd_fire  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid_r <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid_r <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op_r             <= cmd.op;
      scissor_enable_r <= cmd.scissor_enable;
      scissor_top_r    <= cmd.scissor_top;
      scissor_left_r   <= cmd.scissor_left;
      scissor_bottom_r <= cmd.scissor_bottom;
      scissor_right_r  <= cmd.scissor_right;
      fill_color_r     <= cmd.fill_color;
    end
  end

  sqtf_start_unit u_start (
    .cfg            (cfg),
    .scissor_enable (scissor_enable_r),
    .scissor_top    (scissor_top_r),
    .scissor_left   (scissor_left_r),
    .scissor_bottom (scissor_bottom_r),
    .scissor_right  (scissor_right_r),
    .fill_color     (fill_color_r),
    .st_next        (start_next)
  );

  sqtf_quad_step u_step (
    .st              (st),
    .row_pair_stride (cfg.row_pair_stride),
    .st_next         (step_next),
    .res             (step_res)
  );

  // a start replaces any running command; an idle step leaves the state alone
  always_comb begin
    st_next = st;
    if (proc_fire) begin
      if (!step_item) begin
        st_next = start_next;
      end else if (st.busy) begin
        st_next = step_next;
      end
    end
  end

  // only busy needs a reset; the rest is loaded by every start
  always_ff @(posedge clk) begin
    if (rst) begin
      st.busy <= 1'b0;
    end else begin
      st.busy <= st_next.busy;
    end
    st.clip_top          <= st_next.clip_top;
    st.clip_left         <= st_next.clip_left;
    st.clip_bottom       <= st_next.clip_bottom;
    st.clip_right        <= st_next.clip_right;
    st.cur_quad_row      <= st_next.cur_quad_row;
    st.cur_quad_col      <= st_next.cur_quad_col;
    st.row_start_address <= st_next.row_start_address;
    st.held_plane_color  <= st_next.held_plane_color;
  end

  // output register: load on a write, drop once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_valid_r <= 1'b0;
    end else if (proc_fire && has_res) begin
      quad_valid_r <= 1'b1;
    end else if (quad.ready) begin
      quad_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && has_res) begin
      quad_r <= step_res;
    end
  end

  assign quad.valid        = quad_valid_r;
  assign quad.quad_address = quad_r.quad_address;
  assign quad.pixel_mask   = quad_r.pixel_mask;
  assign quad.plane_color  = quad_r.plane_color;
  assign quad.last_write   = quad_r.last_write;

  // every issued quad covers at least one pixel of the rectangle
  a_mask_nonzero: assert property (@(posedge clk) disable iff (rst)
    quad.valid |-> (quad.pixel_mask != '0))
    else $error("quad write with empty pixel mask");

  // the final write of a command leaves the walk idle
  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && has_res && step_res.last_write) |=> !st.busy)
    else $error("walk still busy after last write");

  // a held command that cannot retire is neither lost nor overwritten
  a_hold_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid_r && !proc_fire) |=> (cmd_valid_r && $stable(op_r) &&
                                     $stable(fill_color_r)))
    else $error("held command lost while stalled");

endmodule

`default_nettype wire

// ===== sim/quad_fill_checker.sv =====
// Checker for the quad fill core: tracks commands, predicts quad writes, compares them.
`timescale 1ns / 1ps

module quad_fill_checker
  import sqtf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  sqtf_cmd_if                   cmd,
  sqtf_quad_if                  quad,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    quads_pending
);

  cfg_t        cfg;
  fill_state_t eng;
  quad_res_t   expected_quads[$];
  int          errs = 0;

  assign fail_count = errs;

  function automatic logic [CLIP_W-1:0] dim_cap(input logic [CFG_DIM_W-1:0] d);
    return (d > MAX_DIM) ? CLIP_W'(MAX_DIM) : d[CLIP_W-1:0];
  endfunction

  function automatic logic [CLIP_W-1:0] clamp_edge(input logic signed [EDGE_W-1:0] v,
                                                   input logic [CLIP_W-1:0] lim);
    if (v < 0) return '0;
    if (int'(v) > int'(lim)) return lim;
    return v[CLIP_W-1:0];
  endfunction

  // Latch a start: clip the rectangle, reorder the color, point at the first quad.
  task automatic latch_clear_command();
    logic [CLIP_W-1:0]  w;
    logic [CLIP_W-1:0]  h;
    logic [COLOR_W-1:0] c;
    logic [63:0]        row_offset;
    w = dim_cap(cfg.buffer_width);
    h = dim_cap(cfg.buffer_height);
    c = cmd.fill_color;
    if (cmd.scissor_enable) begin
      eng.clip_top    = clamp_edge(cmd.scissor_top, h);
      eng.clip_left   = clamp_edge(cmd.scissor_left, w);
      eng.clip_bottom = clamp_edge(cmd.scissor_bottom, h);
      eng.clip_right  = clamp_edge(cmd.scissor_right, w);
    end else begin
      eng.clip_top    = '0;
      eng.clip_left   = '0;
      eng.clip_bottom = h;
      eng.clip_right  = w;
    end
    eng.held_plane_color  = {c[31:24], c[15:8], c[23:16], c[7:0]};
    eng.cur_quad_row      = eng.clip_top[CLIP_W-1:1];
    eng.cur_quad_col      = eng.clip_left[CLIP_W-1:1];
    row_offset            = 64'(eng.cur_quad_row) * 64'(cfg.row_pair_stride);
    eng.row_start_address = cfg.base_address + row_offset[ADDR_W-1:0];
    eng.busy = (eng.clip_top < eng.clip_bottom) && (eng.clip_left < eng.clip_right);
  endtask

  // Issue one quad write of the running command and advance the walk.
  task automatic issue_quad_write();
    quad_res_t         q;
    logic [CLIP_W-1:0] right_px;
    logic [CLIP_W-1:0] bottom_px;
    logic [QW-1:0]     last_col;
    logic [QW-1:0]     last_row;
    int                x;
    int                y;
    right_px  = eng.clip_right - 1'b1;
    bottom_px = eng.clip_bottom - 1'b1;
    last_col  = right_px[CLIP_W-1:1];
    last_row  = bottom_px[CLIP_W-1:1];
    q.pixel_mask = '0;
    for (int s = 0; s < 4; s++) begin
      x = 2 * int'(eng.cur_quad_col) + (s & 1);
      y = 2 * int'(eng.cur_quad_row) + (s >> 1);
      if (x >= int'(eng.clip_left) && x < int'(eng.clip_right) &&
          y >= int'(eng.clip_top) && y < int'(eng.clip_bottom)) begin
        q.pixel_mask[s] = 1'b1;
      end
    end
    q.quad_address = eng.row_start_address + (ADDR_W'(eng.cur_quad_col) << QUAD_SHIFT);
    q.plane_color  = eng.held_plane_color;
    q.last_write   = 1'b0;
    if (eng.cur_quad_col < last_col) begin
      eng.cur_quad_col = eng.cur_quad_col + 1'b1;
    end else if (eng.cur_quad_row < last_row) begin
      eng.cur_quad_row      = eng.cur_quad_row + 1'b1;
      eng.cur_quad_col      = eng.clip_left[CLIP_W-1:1];
      eng.row_start_address = eng.row_start_address + ADDR_W'(cfg.row_pair_stride);
    end else begin
      q.last_write = 1'b1;
      eng.busy     = 1'b0;
    end
    expected_quads.push_back(q);
  endtask

  task automatic flag_field(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    quad_res_t want;
    if (rst) begin
      cfg.buffer_width    = CFG_DIM_W'(640);
      cfg.buffer_height   = CFG_DIM_W'(480);
      cfg.base_address    = '0;
      cfg.row_pair_stride = STRIDE_W'(5120);
      eng = '0;
      expected_quads.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BUFFER_WIDTH:    cfg.buffer_width    = cfg_data[CFG_DIM_W-1:0];
          REG_BUFFER_HEIGHT:   cfg.buffer_height   = cfg_data[CFG_DIM_W-1:0];
          REG_BASE_ADDRESS:    cfg.base_address    = cfg_data[ADDR_W-1:0];
          REG_ROW_PAIR_STRIDE: cfg.row_pair_stride = cfg_data[STRIDE_W-1:0];
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        if (cmd.op == OP_START) latch_clear_command();
        else if (eng.busy) issue_quad_write();
      end
      if (quad.valid && quad.ready) begin
        if (expected_quads.size() == 0) begin
          errs++;
          $display("%0t: quad write expected none actual address %h mask %h",
                   $time, quad.quad_address, quad.pixel_mask);
        end else begin
          want = expected_quads.pop_front();
          flag_field("quad_address", want.quad_address, quad.quad_address);
          flag_field("pixel_mask", 32'(want.pixel_mask), 32'(quad.pixel_mask));
          flag_field("plane_color", want.plane_color, quad.plane_color);
          flag_field("last_write", 32'(want.last_write), 32'(quad.last_write));
        end
      end
    end
    quads_pending = expected_quads.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives clear commands and register writes into the fill core.
`timescale 1ns / 1ps

module tb;
  import sqtf_pkg::*;

  // Generous bound: every command waiting out a full sender gap and a full
  // receiver stall is well under a fifth of this.
  localparam int CYCLE_LIMIT     = 200000;
  // Command register plus decode stage, with margin.
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    op_t                      op;
    logic                     en;
    logic signed [EDGE_W-1:0] sc_top;
    logic signed [EDGE_W-1:0] sc_left;
    logic signed [EDGE_W-1:0] sc_bottom;
    logic signed [EDGE_W-1:0] sc_right;
    logic [COLOR_W-1:0]       color;
  } fill_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Sender and receiver idling controls.
  logic tx_gaps   = 1'b0;
  logic rx_stalls = 1'b0;
  logic calm      = 1'b0;
  logic drain_ready = 1'b0;
  int   sink_stall_left = 0;

  int cycle_count = 0;
  int items_sent  = 0;
  int cur_w = 640;
  int cur_h = 480;

  int fail_count;
  int quads_pending;

  sqtf_cmd_if  cmd_ch ();
  sqtf_quad_if quad_ch ();

  assign quad_ch.ready = drain_ready;

  always #6 clk = ~clk;

  scissored_quad_tiled_fill_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .quad      (quad_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  quad_fill_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_ch),
    .quad          (quad_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .quads_pending (quads_pending)
  );

  // Watchdog: end the run with a mismatch once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure: hold ready low in random bursts.
  always @(posedge clk) begin
    if (calm || !rx_stalls) begin
      drain_ready     <= 1'b1;
      sink_stall_left <= 0;
    end else if (sink_stall_left > 1) begin
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_stall_left == 1) begin
      sink_stall_left <= 0;
      drain_ready     <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      drain_ready     <= 1'b0;
      sink_stall_left <= $urandom_range(1, 6);
    end else begin
      drain_ready <= 1'b1;
    end
  end

  function automatic int rand_edge();
    return int'($urandom_range(0, 8192)) - 4096;
  endfunction

  function automatic int clamp_to(input int v, input int lim);
    return (v < 0) ? 0 : ((v > lim) ? lim : v);
  endfunction

  // Count the quad writes a start will produce, for planning the steps.
  function automatic int quads_in(input logic en, input int t, input int l,
                                  input int b, input int r);
    int ct;
    int cl;
    int cb;
    int cr;
    ct = en ? clamp_to(t, cur_h) : 0;
    cl = en ? clamp_to(l, cur_w) : 0;
    cb = en ? clamp_to(b, cur_h) : cur_h;
    cr = en ? clamp_to(r, cur_w) : cur_w;
    if (ct >= cb || cl >= cr) return 0;
    return ((cb - 1) / 2 - ct / 2 + 1) * ((cr - 1) / 2 - cl / 2 + 1);
  endfunction

  // Present one command and hold it until the core takes the transaction.
  // Valid stays high when the next command follows back to back.
  task automatic send_cmd(input fill_cmd_t c);
    cmd_ch.valid          <= 1'b1;
    cmd_ch.op             <= c.op;
    cmd_ch.scissor_enable <= c.en;
    cmd_ch.scissor_top    <= c.sc_top;
    cmd_ch.scissor_left   <= c.sc_left;
    cmd_ch.scissor_bottom <= c.sc_bottom;
    cmd_ch.scissor_right  <= c.sc_right;
    cmd_ch.fill_color     <= c.color;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    items_sent++;
    if (!calm && tx_gaps && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_start(input logic en, input int t, input int l, input int b,
                            input int r, input logic [COLOR_W-1:0] color);
    fill_cmd_t c;
    c.op        = OP_START;
    c.en        = en;
    c.sc_top    = t[EDGE_W-1:0];
    c.sc_left   = l[EDGE_W-1:0];
    c.sc_bottom = b[EDGE_W-1:0];
    c.sc_right  = r[EDGE_W-1:0];
    c.color     = color;
    send_cmd(c);
  endtask

  // A step carries junk in the unused fields so they toggle too.
  task automatic send_step();
    fill_cmd_t c;
    int        junk;
    c.op        = OP_STEP;
    c.en        = 1'($urandom_range(0, 1));
    junk        = rand_edge();
    c.sc_top    = junk[EDGE_W-1:0];
    junk        = rand_edge();
    c.sc_left   = junk[EDGE_W-1:0];
    junk        = rand_edge();
    c.sc_bottom = junk[EDGE_W-1:0];
    junk        = rand_edge();
    c.sc_right  = junk[EDGE_W-1:0];
    c.color     = $urandom();
    send_cmd(c);
  endtask

  // Drop valid and hold until every predicted quad write has come out.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (quads_pending != 0) @(posedge clk);
  endtask

  // Write all four registers back to back; the core must be idle.
  task automatic apply_config(input int w, input int h, input logic [31:0] base,
                              input int stride);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BUFFER_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= REG_BUFFER_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= REG_BASE_ADDRESS;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= REG_ROW_PAIR_STRIDE;
    cfg_data  <= CFG_DATA_W'(stride);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = (w > MAX_DIM) ? MAX_DIM : w;
    cur_h = (h > MAX_DIM) ? MAX_DIM : h;
  endtask

  // One random sequence: mostly a start followed by exactly the steps it
  // needs, sometimes cut short, padded, empty, whole-buffer or pure noise.
  task automatic run_sequence();
    int   kind;
    int   t;
    int   l;
    int   b;
    int   r;
    int   n;
    int   steps;
    int   span;
    logic en;
    kind = $urandom_range(0, 99);
    en   = 1'b1;
    t    = $urandom_range(0, cur_h - 1);
    b    = t + $urandom_range(1, (cur_h - t < 8) ? cur_h - t : 8);
    l    = $urandom_range(0, cur_w - 1);
    r    = l + $urandom_range(1, (cur_w - l < 8) ? cur_w - l : 8);
    if (kind < 70) begin
      // push one scissor edge past the buffer now and then
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            span = (cur_h < 6) ? cur_h : 6;
            t = -int'($urandom_range(1, 4096));
            b = $urandom_range(1, span);
          end
          1: begin
            span = (cur_w < 6) ? cur_w : 6;
            l = -int'($urandom_range(1, 4096));
            r = $urandom_range(1, span);
          end
          2: begin
            span = (cur_h < 6) ? cur_h : 6;
            b = $urandom_range(cur_h, 4096);
            t = cur_h - int'($urandom_range(1, span));
          end
          default: begin
            span = (cur_w < 6) ? cur_w : 6;
            r = $urandom_range(cur_w, 4096);
            l = cur_w - int'($urandom_range(1, span));
          end
        endcase
      end
    end else if (kind < 80) begin
      // collapse or invert one axis
      if ($urandom_range(0, 1) == 1) b = t - int'($urandom_range(0, 4));
      else r = l - int'($urandom_range(0, 4));
    end else if (kind < 90) begin
      if (cur_w * cur_h <= 128) en = 1'b0;
    end else begin
      t = rand_edge();
      l = rand_edge();
      b = rand_edge();
      r = rand_edge();
    end
    n = quads_in(en, t, l, b, r);
    steps = (kind >= 90) ? $urandom_range(0, 4) : n;
    if (kind < 70 && n > 1 && $urandom_range(0, 6) == 0) steps = $urandom_range(1, n - 1);
    if ($urandom_range(0, 9) == 0) steps += $urandom_range(1, 3);
    send_start(en, t, l, b, r, $urandom());
    repeat (steps) send_step();
  endtask

  initial begin
    int          w;
    int          h;
    int          stride;
    logic [31:0] base;

    cmd_ch.valid          <= 1'b0;
    cmd_ch.op             <= OP_STEP;
    cmd_ch.scissor_enable <= 1'b0;
    cmd_ch.scissor_top    <= '0;
    cmd_ch.scissor_left   <= '0;
    cmd_ch.scissor_bottom <= '0;
    cmd_ch.scissor_right  <= '0;
    cmd_ch.fill_color     <= '0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_BUFFER_WIDTH;
    cfg_data              <= '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset register values (640 x 480, stride 5120).
    send_step();                                    // step with nothing running
    send_start(1'b1, -4096, 637, 3, 4096, 32'hFFFF_FFFF);  // edges clamp to buffer
    repeat (4) send_step();
    send_step();                                    // step past the last write
    send_start(1'b1, 4096, -4096, -4096, 4096, 32'h0000_0000);  // empty after clamp
    send_step();
    send_start(1'b1, 1, 1, 2, 2, 32'h1234_5678);   // lone lower-right pixel
    send_step();
    send_start(1'b0, 0, 0, 0, 0, 32'hA5C3_0F96);   // whole buffer, cut short
    repeat (2) send_step();
    send_start(1'b1, 0, 0, 1, 1, 32'h0F1E_2D3C);   // start replaces the running one
    send_step();
    send_start(1'b1, 8, 8, 2, 20, 32'h5A5A_A5A5);  // inverted rectangle
    send_step();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Whole-buffer clear on an odd-sized buffer: partial quads on the right and bottom sides.
    apply_config(3, 5, 32'h0000_1000, 64);
    send_start(1'b0, 0, 0, 0, 0, 32'hC0DE_F00D);
    repeat (6) send_step();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin w = 1;    h = 1;    base = 32'hFFFF_FFF0; stride = 1048576; end
        1: begin w = 4096; h = 4096; base = 32'h0000_0000; stride = 0; end
        2: begin w = 4096; h = 1;    base = 32'h7FFF_FFF0; stride = $urandom_range(0, 1048576); end
        default: begin
          case ($urandom_range(0, 3))
            0: w = $urandom_range(1, 16);
            1: w = 4096;
            default: w = $urandom_range(1, 4096);
          endcase
          case ($urandom_range(0, 3))
            0: h = $urandom_range(1, 16);
            1: h = 4096;
            default: h = $urandom_range(1, 4096);
          endcase
          base = $urandom() & 32'hFFFF_FFF0;
          case ($urandom_range(0, 3))
            0: stride = 0;
            1: stride = 1048576;
            default: stride = $urandom_range(0, 1048576);
          endcase
        end
      endcase
      apply_config(w, h, base, stride);
      // the last phase runs with no idling on either side
      calm       <= (p == RANDOM_PHASES - 1);
      tx_gaps    <= 1'($urandom_range(0, 1));
      rx_stalls  <= 1'($urandom_range(0, 1));
      items_sent = 0;
      while (items_sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 29) == 0) begin
          tx_gaps   <= 1'($urandom_range(0, 1));
          rx_stalls <= 1'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 39) == 0) wait_drained();
        run_sequence();
      end
      // an empty start leaves the engine idle before the registers change
      send_start(1'b1, 0, 0, 0, 0, $urandom());
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (fail_count == 0 && quads_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sqtf_pkg.sv
rtl/core/sqtf_cmd_if.sv
rtl/core/sqtf_quad_if.sv
rtl/core/sqtf_start_unit.sv
rtl/core/sqtf_quad_step.sv
rtl/core/scissored_quad_tiled_fill_core.sv
sim/quad_fill_checker.sv
sim/tb.sv
